@@ design/qrs_pkg.sv @@
package qrs_pkg;

    localparam int DATA_W        = 32;
    localparam int EPS_W         = 16;
    localparam int FRAC_BITS_DEF = 16;

    localparam logic [EPS_W-1:0] EPS_RESET = 16'd7;

    // Codes of root_case.
    localparam logic [1:0] CASE_NONE = 2'd0;
    localparam logic [1:0] CASE_ONE  = 2'd1;
    localparam logic [1:0] CASE_TWO  = 2'd2;
    localparam logic [1:0] CASE_INF  = 2'd3;

    // The discriminant b*b - 4*a*c is held in 67 bits signed; its magnitude fits in 66.
    localparam int DISC_W  = 67;
    localparam int RAD_W   = 66;
    localparam int ROOT_W  = RAD_W / 2;
    localparam int SREM_W  = ROOT_W + 3;

    // Numerators -b +/- sqrt(d) and -c fit in 35 bits signed, 34 bits of magnitude.
    localparam int NUM_W     = 35;
    localparam int NUM_MAG_W = 34;
    // Denominators 2*a and b fit in 34 bits signed, 33 bits of magnitude.
    localparam int DEN_W     = 34;
    localparam int DEN_MAG_W = 33;

    localparam logic [DATA_W-1:0] POS_LIMIT = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] NEG_LIMIT = 32'h8000_0000;

    typedef struct packed {
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        logic [DATA_W-1:0] c;
        logic              az;
        logic              bz;
        logic              cz;
        logic              dneg;
        logic              dzero;
    } sq_side_t;

    typedef struct packed {
        logic [1:0] rcase;
        logic       v1;
        logic       v2;
        logic       neg1;
        logic       neg2;
    } dv_side_t;

    function automatic logic [DATA_W:0] mag32(input logic [DATA_W-1:0] v);
        logic [DATA_W:0] ext;
        ext = {v[DATA_W-1], v};
        return v[DATA_W-1] ? -ext : ext;
    endfunction

endpackage

@@ design/qrs_if.sv @@
interface qrs_cfg_if import qrs_pkg::*;;
    logic             valid;
    logic             ready;
    logic [EPS_W-1:0] zero_epsilon;

    modport source (output valid, output zero_epsilon, input ready);
    modport sink   (input valid, input zero_epsilon, output ready);
endinterface

interface qrs_coef_if import qrs_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] coef_a;
    logic signed [DATA_W-1:0] coef_b;
    logic signed [DATA_W-1:0] coef_c;

    modport source (output valid, output coef_a, output coef_b, output coef_c, input ready);
    modport sink   (input valid, input coef_a, input coef_b, input coef_c, output ready);
endinterface

interface qrs_root_if import qrs_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic [1:0]               root_case;
    logic signed [DATA_W-1:0] root_one;
    logic signed [DATA_W-1:0] root_two;
    logic                     root_one_valid;
    logic                     root_two_valid;
    logic                     overflow;

    modport source (output valid, output root_case, output root_one, output root_two,
                    output root_one_valid, output root_two_valid, output overflow,
                    input ready);
    modport sink   (input valid, input root_case, input root_one, input root_two,
                    input root_one_valid, input root_two_valid, input overflow,
                    output ready);
endinterface

@@ design/qrs_div.sv @@
// Unsigned restoring divider, one quotient bit per register stage.
module qrs_div #(
    parameter int NW = 50,
    parameter int DW = 33
) (
    input  logic          clk,
    input  logic          en,
    input  logic [NW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output logic [NW-1:0] quotient
);

    logic [DW+NW-1:0] acc_reg [NW];
    logic [DW-1:0]    dvs_reg [NW];

    for (genvar k = 0; k < NW; k++) begin : g_step
        logic [DW+NW-1:0] acc_in;
        logic [DW-1:0]    dvs_in;
        logic [DW:0]      top;
        logic [DW:0]      diff;
        logic             take;
        logic [DW+NW-1:0] acc_next;

        if (k == 0) begin : g_first
            assign acc_in = {{DW{1'b0}}, dividend};
            assign dvs_in = divisor;
        end
        else begin : g_rest
            assign acc_in = acc_reg[k-1];
            assign dvs_in = dvs_reg[k-1];
        end

        // The partial remainder shifted left by one is compared with the divisor.
        assign top      = acc_in[DW+NW-1:NW-1];
        assign diff     = top - {1'b0, dvs_in};
        assign take     = top >= {1'b0, dvs_in};
        assign acc_next = {(take ? diff[DW-1:0] : top[DW-1:0]), acc_in[NW-2:0], take};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                acc_reg[k] <= acc_next;
                dvs_reg[k] <= dvs_in;
            end
        end
    end

    assign quotient = acc_reg[NW-1][NW-1:0];

endmodule

@@ design/quadratic_root_solver.sv @@
// Real roots of a*x^2 + b*x + c = 0 for signed fixed-point coefficients with FRAC_BITS
// fraction bits (Q16.16 by default). The block is a fully pipelined datapath that takes
// one item per cycle while the output does not stall and returns one result per item,
// in order. Most of its depth lies in the square root of the discriminant (33 stages)
// and the two parallel restoring dividers (34 + FRAC_BITS stages). The whole pipeline
// moves when the output register is empty or being taken, so coef.ready follows
// root.ready while a result is held. zero_epsilon may be written at any time the
// pipeline holds no item.
module quadratic_root_solver import qrs_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    qrs_cfg_if.sink        cfg,
    qrs_coef_if.sink       coef,
    qrs_root_if.source     root
);

    localparam int NW    = NUM_MAG_W + FRAC_BITS;
    localparam int TOL_W = EPS_W + FRAC_BITS;
    localparam int SQ_N  = ROOT_W;

    logic adv;
    logic [EPS_W-1:0] eps_reg;
    logic [TOL_W-1:0] tol;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            eps_reg <= EPS_RESET;
        else if (cfg.valid)
            eps_reg <= cfg.zero_epsilon;
    end

    assign cfg.ready = 1'b1;
    assign tol       = {eps_reg, {FRAC_BITS{1'b0}}};

    logic out_v_reg;
    assign adv        = !out_v_reg || root.ready;
    assign coef.ready = adv;

    // ---------------- Input register ----------------
    logic              v0_reg;
    logic [DATA_W-1:0] a0_reg, b0_reg, c0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else if (adv)
            v0_reg <= coef.valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a0_reg <= coef.coef_a;
            b0_reg <= coef.coef_b;
            c0_reg <= coef.coef_c;
        end
    end

    // ---------------- Products and zero tests ----------------
    logic                     v1_reg;
    logic [63:0]              bb1_reg;
    logic signed [63:0]       ac1_reg;
    sq_side_t                 side1_reg, side1_next;

    always_comb
    begin
        side1_next       = '0;
        side1_next.a     = a0_reg;
        side1_next.b     = b0_reg;
        side1_next.c     = c0_reg;
        side1_next.az    = mag32(a0_reg) <= (DATA_W+1)'(eps_reg);
        side1_next.bz    = mag32(b0_reg) <= (DATA_W+1)'(eps_reg);
        side1_next.cz    = mag32(c0_reg) <= (DATA_W+1)'(eps_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (adv)
            v1_reg <= v0_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            bb1_reg   <= $signed(b0_reg) * $signed(b0_reg);
            ac1_reg   <= $signed(a0_reg) * $signed(c0_reg);
            side1_reg <= side1_next;
        end
    end

    // ---------------- Discriminant ----------------
    logic                     v2_reg;
    logic signed [DISC_W-1:0] d2_reg, d2_next;
    sq_side_t                 side2_reg;

    assign d2_next = $signed({3'b000, bb1_reg}) - $signed({ac1_reg[63], ac1_reg, 2'b00});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (adv)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d2_reg    <= d2_next;
            side2_reg <= side1_reg;
        end
    end

    // ---------------- Magnitude of the discriminant ----------------
    logic              v3_reg;
    logic [RAD_W-1:0]  dmag3_reg, dmag3_next;
    sq_side_t          side3_reg, side3_next;

    always_comb
    begin
        side3_next      = side2_reg;
        side3_next.dneg = d2_reg[DISC_W-1];
        dmag3_next      = d2_reg[DISC_W-1] ? RAD_W'(-d2_reg) : RAD_W'(d2_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (adv)
            v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dmag3_reg <= dmag3_next;
            side3_reg <= side3_next;
        end
    end

    // ---------------- Near-zero discriminant test ----------------
    logic              v4_reg;
    logic [RAD_W-1:0]  rad4_reg;
    sq_side_t          side4_reg, side4_next;

    always_comb
    begin
        side4_next       = side3_reg;
        side4_next.dzero = dmag3_reg <= RAD_W'(tol);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v4_reg <= 1'b0;
        else if (adv)
            v4_reg <= v3_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rad4_reg  <= dmag3_reg;
            side4_reg <= side4_next;
        end
    end

    // ---------------- Square root, one result bit per stage ----------------
    logic              sq_v_reg    [SQ_N];
    sq_side_t          sq_side_reg [SQ_N];
    logic [RAD_W-1:0]  sq_rad_reg  [SQ_N];
    logic [SREM_W-1:0] sq_rem_reg  [SQ_N];
    logic [ROOT_W-1:0] sq_root_reg [SQ_N];

    for (genvar k = 0; k < SQ_N; k++) begin : g_sq
        logic              v_in;
        sq_side_t          side_in;
        logic [RAD_W-1:0]  rad_in;
        logic [SREM_W-1:0] rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [SREM_W-1:0] rem_sh;
        logic [SREM_W-1:0] trial;
        logic              take;
        logic [SREM_W-1:0] rem_next;
        logic [ROOT_W-1:0] root_next;
        logic [RAD_W-1:0]  rad_next;

        if (k == 0) begin : g_first
            assign v_in    = v4_reg;
            assign side_in = side4_reg;
            assign rad_in  = rad4_reg;
            assign rem_in  = '0;
            assign root_in = '0;
        end
        else begin : g_rest
            assign v_in    = sq_v_reg[k-1];
            assign side_in = sq_side_reg[k-1];
            assign rad_in  = sq_rad_reg[k-1];
            assign rem_in  = sq_rem_reg[k-1];
            assign root_in = sq_root_reg[k-1];
        end

        // Bring down the next two radicand bits and try the trial divisor 4*root + 1.
        assign rem_sh    = {rem_in[SREM_W-3:0], rad_in[RAD_W-1:RAD_W-2]};
        assign trial     = SREM_W'({root_in, 2'b01});
        assign take      = rem_sh >= trial;
        assign rem_next  = take ? rem_sh - trial : rem_sh;
        assign root_next = {root_in[ROOT_W-2:0], take};
        assign rad_next  = {rad_in[RAD_W-3:0], 2'b00};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sq_v_reg[k] <= 1'b0;
            else if (adv)
                sq_v_reg[k] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq_side_reg[k] <= side_in;
                sq_rad_reg[k]  <= rad_next;
                sq_rem_reg[k]  <= rem_next;
                sq_root_reg[k] <= root_next;
            end
        end
    end

    // ---------------- Numerators, denominator and case ----------------
    sq_side_t                 sd;
    logic [ROOT_W-1:0]        sroot;
    logic signed [NUM_W-1:0]  nb, nc, sx;
    logic                     v5_reg;
    logic signed [NUM_W-1:0]  num1_reg, num1_next, num2_reg, num2_next;
    logic signed [DEN_W-1:0]  den5_reg, den5_next;
    dv_side_t                 dside5_reg, dside5_next;

    assign sd    = sq_side_reg[SQ_N-1];
    assign sroot = sq_root_reg[SQ_N-1];
    assign nb    = -(NUM_W'($signed(sd.b)));
    assign nc    = -(NUM_W'($signed(sd.c)));
    assign sx    = $signed({2'b00, sroot});

    always_comb
    begin
        dside5_next = '0;
        num1_next   = nb + sx;
        num2_next   = nb - sx;
        den5_next   = $signed({sd.a[DATA_W-1], sd.a, 1'b0});
        if (sd.az)
        begin
            // Linear equation b*x + c = 0.
            num1_next = nc;
            den5_next = DEN_W'($signed(sd.b));
            if (!sd.bz)
            begin
                dside5_next.rcase = CASE_ONE;
                dside5_next.v1    = 1'b1;
            end
            else if (sd.cz)
                dside5_next.rcase = CASE_INF;
            else
                dside5_next.rcase = CASE_NONE;
        end
        else if (sd.dzero)
        begin
            num1_next         = nb;
            num2_next         = nb;
            dside5_next.rcase = CASE_TWO;
            dside5_next.v1    = 1'b1;
            dside5_next.v2    = 1'b1;
        end
        else if (!sd.dneg)
        begin
            dside5_next.rcase = CASE_TWO;
            dside5_next.v1    = 1'b1;
            dside5_next.v2    = 1'b1;
        end
        else
            dside5_next.rcase = CASE_NONE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v5_reg <= 1'b0;
        else if (adv)
            v5_reg <= sq_v_reg[SQ_N-1];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            num1_reg   <= num1_next;
            num2_reg   <= num2_next;
            den5_reg   <= den5_next;
            dside5_reg <= dside5_next;
        end
    end

    // ---------------- Magnitudes and quotient signs ----------------
    logic                 v6_reg;
    logic [NUM_MAG_W-1:0] m1_reg, m2_reg;
    logic [DEN_MAG_W-1:0] dm_reg;
    dv_side_t             dside6_reg, dside6_next;

    always_comb
    begin
        dside6_next      = dside5_reg;
        dside6_next.neg1 = num1_reg[NUM_W-1] ^ den5_reg[DEN_W-1];
        dside6_next.neg2 = num2_reg[NUM_W-1] ^ den5_reg[DEN_W-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v6_reg <= 1'b0;
        else if (adv)
            v6_reg <= v5_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m1_reg     <= num1_reg[NUM_W-1] ? NUM_MAG_W'(-num1_reg) : NUM_MAG_W'(num1_reg);
            m2_reg     <= num2_reg[NUM_W-1] ? NUM_MAG_W'(-num2_reg) : NUM_MAG_W'(num2_reg);
            dm_reg     <= den5_reg[DEN_W-1] ? DEN_MAG_W'(-den5_reg) : DEN_MAG_W'(den5_reg);
            dside6_reg <= dside6_next;
        end
    end

    // ---------------- Dividers ----------------
    logic [NW-1:0] q1, q2;

    qrs_div #(.NW(NW), .DW(DEN_MAG_W)) u_div_one (
        .clk      (clk),
        .en       (adv),
        .dividend ({m1_reg, {FRAC_BITS{1'b0}}}),
        .divisor  (dm_reg),
        .quotient (q1)
    );

    qrs_div #(.NW(NW), .DW(DEN_MAG_W)) u_div_two (
        .clk      (clk),
        .en       (adv),
        .dividend ({m2_reg, {FRAC_BITS{1'b0}}}),
        .divisor  (dm_reg),
        .quotient (q2)
    );

    logic     dv_v_reg    [NW];
    dv_side_t dv_side_reg [NW];

    for (genvar k = 0; k < NW; k++) begin : g_dv
        logic     v_in;
        dv_side_t side_in;

        if (k == 0) begin : g_first
            assign v_in    = v6_reg;
            assign side_in = dside6_reg;
        end
        else begin : g_rest
            assign v_in    = dv_v_reg[k-1];
            assign side_in = dv_side_reg[k-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_v_reg[k] <= 1'b0;
            else if (adv)
                dv_v_reg[k] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
                dv_side_reg[k] <= side_in;
        end
    end

    // ---------------- Saturation and zero-snap tests ----------------
    dv_side_t          fs;
    logic              f_v_reg;
    dv_side_t          f_side_reg;
    logic [DATA_W-1:0] f_q1_reg, f_q2_reg;
    logic              f_ovf1_reg, f_ovf2_reg, f_snap1_reg, f_snap2_reg;

    assign fs = dv_side_reg[NW-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f_v_reg <= 1'b0;
        else if (adv)
            f_v_reg <= dv_v_reg[NW-1];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f_side_reg  <= fs;
            f_q1_reg    <= q1[DATA_W-1:0];
            f_q2_reg    <= q2[DATA_W-1:0];
            f_ovf1_reg  <= fs.neg1 ? (q1 > NW'(NEG_LIMIT)) : (q1 > NW'(POS_LIMIT));
            f_ovf2_reg  <= fs.neg2 ? (q2 > NW'(NEG_LIMIT)) : (q2 > NW'(POS_LIMIT));
            f_snap1_reg <= q1 <= NW'(eps_reg);
            f_snap2_reg <= q2 <= NW'(eps_reg);
        end
    end

    // ---------------- Output register ----------------
    logic [DATA_W-1:0] r1_next, r2_next;
    logic [1:0]        rcase_reg;
    logic [DATA_W-1:0] r1_reg, r2_reg;
    logic              rv1_reg, rv2_reg, ovf_reg;

    always_comb
    begin
        if (!f_side_reg.v1 || (f_snap1_reg && !f_ovf1_reg))
            r1_next = '0;
        else if (f_ovf1_reg)
            r1_next = f_side_reg.neg1 ? NEG_LIMIT : POS_LIMIT;
        else
            r1_next = f_side_reg.neg1 ? -f_q1_reg : f_q1_reg;

        if (!f_side_reg.v2 || (f_snap2_reg && !f_ovf2_reg))
            r2_next = '0;
        else if (f_ovf2_reg)
            r2_next = f_side_reg.neg2 ? NEG_LIMIT : POS_LIMIT;
        else
            r2_next = f_side_reg.neg2 ? -f_q2_reg : f_q2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (adv)
            out_v_reg <= f_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rcase_reg <= f_side_reg.rcase;
            r1_reg    <= r1_next;
            r2_reg    <= r2_next;
            rv1_reg   <= f_side_reg.v1;
            rv2_reg   <= f_side_reg.v2;
            ovf_reg   <= (f_side_reg.v1 && f_ovf1_reg) || (f_side_reg.v2 && f_ovf2_reg);
        end
    end

    assign root.valid          = out_v_reg;
    assign root.root_case      = rcase_reg;
    assign root.root_one       = $signed(r1_reg);
    assign root.root_two       = $signed(r2_reg);
    assign root.root_one_valid = rv1_reg;
    assign root.root_two_valid = rv2_reg;
    assign root.overflow       = ovf_reg;

`ifndef NO_ASSERTIONS
    // Cases without a finite root set report no root and no saturation.
    a_no_root_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (root.valid && (root.root_case == CASE_NONE || root.root_case == CASE_INF))
        |-> (!root.root_one_valid && !root.root_two_valid && !root.overflow
             && root.root_one == 0 && root.root_two == 0))
        else $error("root fields set for a case without roots");

    // A single root lives in the first lane only.
    a_one_root_lane: assert property (@(posedge clk) disable iff (!rst_n)
        (root.valid && root.root_case == CASE_ONE)
        |-> (root.root_one_valid && !root.root_two_valid && root.root_two == 0))
        else $error("single root case with wrong lane flags");

    // The second lane carries a root only in the two-root case.
    a_two_root_lane: assert property (@(posedge clk) disable iff (!rst_n)
        (root.valid && root.root_two_valid)
        |-> (root.root_case == CASE_TWO && root.root_one_valid))
        else $error("second root valid outside the two-root case");

    // While the output stalls, the pipeline must freeze and accept nothing.
    a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        (out_v_reg && !root.ready) |-> (!coef.ready ##1 $stable(f_v_reg)))
        else $error("pipeline moved during an output stall");
`endif

endmodule
